// ----- rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the dual-mode serial frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfr_pkg;

    // default sizing
    localparam int DEFAULT_BUFFER_DEPTH  = 128;
    localparam int DEFAULT_HEADER_LENGTH = 6;

    // fixed field widths
    localparam int KIND_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 7;
    localparam int EXP_LEN_W  = 17;

    // word kinds
    localparam logic [KIND_W-1:0] KIND_RX_BYTE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RESP_SENT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TX_DONE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TAKE_CMD  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_BUF  = 3'd4;

    // framing marks
    localparam logic [BYTE_W-1:0] OPEN_MARK  = 8'h3C;
    localparam logic [BYTE_W-1:0] CLOSE_MARK = 8'h3E;

    // command framing state
    typedef enum logic [2:0] {
        BR_IDLE   = 3'b001,
        BR_OPEN   = 3'b010,
        BR_CLOSED = 3'b100
    } t_bracket;

endpackage

// ----- rtl/sfr_ram.sv -----
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/serial_frame_receiver_dual_mode.sv -----
// ----------------------------------------------------------------------------
// serial_frame_receiver_dual_mode
// Serial byte receiver with angle-bracket command framing or Modbus TCP
// length framing, storing bytes in a wrapping receive buffer.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | i_in_valid / o_in_ready, kind, byte, index | in
//  result   | o_out_valid / i_out_ready, six fields      | out
//  config   | i_cfg_we / i_cfg_data (command_mode)       | in
//
//  One word per cycle while input ready holds; the accepting edge loads the
//  middle stage and starts the buffer read, then the result register is loaded
//  from the middle stage once it is empty or being taken, and offers the result.
//  State is updated at the accepting edge, so back-to-back words always see
//  the effect of the previous one, buffer reads included.
//  A stalled result holds the result register and then the middle stage;
//  input ready drops only when both are full.
//  Reset is synchronous, active low; the buffer itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_receiver_dual_mode
    import sfr_pkg::*;
#(
    parameter int BUFFER_DEPTH  = DEFAULT_BUFFER_DEPTH,
    parameter int HEADER_LENGTH = DEFAULT_HEADER_LENGTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    input  logic [INDEX_W-1:0] i_read_index,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [INDEX_W-1:0] o_byte_count,
    output logic               o_ready_event,
    output logic               o_frame_received,
    output logic               o_command_ready,
    output logic [INDEX_W-1:0] o_taken_length,
    output logic [BYTE_W-1:0]  o_read_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    // one bit above the wider of index and address, so the depth itself fits
    localparam int IW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);
    localparam logic [AW-1:0] HDR_HI_ADDR = AW'((HEADER_LENGTH - 2) % BUFFER_DEPTH);
    localparam logic [EXP_LEN_W-1:0] HDR_LEN = EXP_LEN_W'(HEADER_LENGTH);

    // architectural state
    logic                 r_cmd_mode;
    logic [AW-1:0]        r_count,   n_count;
    t_bracket             r_bracket, n_bracket;
    logic                 r_busy,    n_busy;
    logic [EXP_LEN_W-1:0] r_exp_len, n_exp_len;
    logic                 r_pending, n_pending;
    logic [BYTE_W-1:0]    r_hdr_hi;

    // middle stage (waiting for buffer read data)
    logic               r_a_valid;
    logic [INDEX_W-1:0] r_a_count;
    logic               r_a_ready_ev;
    logic               r_a_frame;
    logic               r_a_pending;
    logic [INDEX_W-1:0] r_a_taken;
    logic               r_a_is_read;

    // result register
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_count;
    logic               r_out_ready_ev;
    logic               r_out_frame;
    logic               r_out_pending;
    logic [INDEX_W-1:0] r_out_taken;
    logic [BYTE_W-1:0]  r_out_rdata;

    // per-word combinational results
    logic               accept;
    logic               a_move;
    logic               n_ready_ev;
    logic               n_frame;
    logic [INDEX_W-1:0] n_taken;
    logic               n_is_read;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      cnt_base;
    logic [AW-1:0]      cnt_inc;
    logic [IW-1:0]      idx_ext;
    logic [BYTE_W-1:0]  ram_rdata;

    // handshake and stage movement
    assign a_move     = r_a_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || a_move;
    assign accept     = i_in_valid && o_in_ready;

    // receive buffer
    sfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_rx_byte),
        .i_re    (accept),
        .i_raddr (AW'(i_read_index)),
        .o_rdata (ram_rdata)
    );

    assign idx_ext = IW'(i_read_index);

    // Modbus: first byte after idle restarts the count
    assign cnt_base = (r_busy || r_cmd_mode) ? r_count : '0;
    assign cnt_inc  = (cnt_base == LAST_ADDR) ? '0 : cnt_base + AW'(1);
    assign wr_addr  = cnt_base;

    // next-state logic for one word
    always_comb begin
        n_count    = r_count;
        n_bracket  = r_bracket;
        n_busy     = r_busy;
        n_exp_len  = r_exp_len;
        n_pending  = r_pending;
        n_ready_ev = 1'b0;
        n_frame    = 1'b0;
        n_taken    = '0;
        n_is_read  = 1'b0;
        wr_en      = 1'b0;

        unique case (i_kind)
            KIND_RX_BYTE: begin
                if (r_cmd_mode) begin
                    unique case (r_bracket)
                        BR_IDLE: begin
                            if (i_rx_byte == OPEN_MARK) begin
                                n_bracket = BR_OPEN;
                            end else if (i_rx_byte == CLOSE_MARK) begin
                                n_bracket = BR_CLOSED;
                            end
                        end
                        BR_OPEN: begin
                            if (i_rx_byte == CLOSE_MARK) begin
                                n_bracket = BR_CLOSED;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = cnt_inc;
                            end
                        end
                        BR_CLOSED: begin
                            n_bracket = BR_CLOSED;
                        end
                        default: begin
                            n_bracket = BR_IDLE;
                        end
                    endcase
                    n_pending = (n_bracket == BR_CLOSED);
                end else begin
                    n_ready_ev = !r_busy;
                    n_busy     = 1'b1;
                    wr_en      = 1'b1;
                    n_count    = cnt_inc;
                    // header complete: length field is the byte before and this byte
                    if (EXP_LEN_W'(cnt_inc) == HDR_LEN) begin
                        n_exp_len = HDR_LEN + EXP_LEN_W'({r_hdr_hi, i_rx_byte});
                    end
                    n_frame = (EXP_LEN_W'(cnt_inc) == n_exp_len);
                end
            end
            KIND_RESP_SENT: begin
                n_busy = 1'b0;
            end
            KIND_TX_DONE: begin
                if (!r_cmd_mode) begin
                    n_count = '0;
                end
            end
            KIND_TAKE_CMD: begin
                if (r_pending) begin
                    n_taken   = INDEX_W'(r_count);
                    n_count   = '0;
                    n_bracket = BR_IDLE;
                    n_pending = 1'b0;
                end
            end
            KIND_READ_BUF: begin
                n_is_read = (idx_ext < IW'(BUFFER_DEPTH));
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_cmd_mode <= i_cfg_data;
        end
    end

    // state update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_bracket <= BR_IDLE;
            r_busy    <= 1'b0;
            r_exp_len <= '0;
            r_pending <= 1'b0;
        end else if (accept) begin
            r_count   <= n_count;
            r_bracket <= n_bracket;
            r_busy    <= n_busy;
            r_exp_len <= n_exp_len;
            r_pending <= n_pending;
        end
    end

    // copy of the buffer entry holding the length high byte
    always_ff @(posedge i_clk) begin
        if (accept && wr_en && (wr_addr == HDR_HI_ADDR)) begin
            r_hdr_hi <= i_rx_byte;
        end
    end

    // middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_count    <= INDEX_W'(n_count);
            r_a_ready_ev <= n_ready_ev;
            r_a_frame    <= n_frame;
            r_a_pending  <= n_pending;
            r_a_taken    <= n_taken;
            r_a_is_read  <= n_is_read;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_out_count    <= r_a_count;
            r_out_ready_ev <= r_a_ready_ev;
            r_out_frame    <= r_a_frame;
            r_out_pending  <= r_a_pending;
            r_out_taken    <= r_a_taken;
            r_out_rdata    <= r_a_is_read ? ram_rdata : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_count     = r_out_count;
    assign o_ready_event    = r_out_ready_ev;
    assign o_frame_received = r_out_frame;
    assign o_command_ready  = r_out_pending;
    assign o_taken_length   = r_out_taken;
    assign o_read_data      = r_out_rdata;

    // pending command exactly when the framing state is closed
    a_pending_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == (r_bracket == BR_CLOSED))
        else $error("pending flag out of step with framing state");

    // write count stays inside the buffer
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EXP_LEN_W'(r_count) < EXP_LEN_W'(BUFFER_DEPTH))
        else $error("write count beyond buffer depth");

    // a ready event leaves the receiver busy
    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_ready_ev |=> r_busy)
        else $error("ready event without busy");

    // a blocked middle stage keeps its word
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !a_move |=> r_a_valid && $stable(r_a_count) && $stable(r_a_is_read))
        else $error("middle stage lost its word while stalled");

    // no ready event or frame event in command mode
    a_cmd_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd_mode |-> !n_ready_ev && !n_frame)
        else $error("Modbus event raised in command mode");

endmodule

// ----- sim/serial_frame_receiver_dual_mode_test.sv -----
// ----------------------------------------------------------------------------
// serial_frame_receiver_dual_mode_test
// Self-checking bench for the dual-mode serial frame receiver. A scoreboard
// class predicts every result word from the accepted input words and checks
// them in order. The run covers directed framing corner cases, then random
// Modbus length frames and bracketed commands under varying back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_receiver_dual_mode_test;
    import sfr_pkg::*;

    localparam int     DEPTH         = DEFAULT_BUFFER_DEPTH;
    localparam int     HEADER_LEN    = DEFAULT_HEADER_LENGTH;
    localparam int     PHASE_WORDS   = 60;
    localparam int     HOLD_CYCLES   = 200;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     MAX_PRINTS    = 40;
    localparam longint TIMEOUT_NS    = 64'd10_000_000;

    // one predicted result word
    typedef struct packed {
        logic [INDEX_W-1:0] byte_count;
        logic               ready_event;
        logic               frame_received;
        logic               command_ready;
        logic [INDEX_W-1:0] taken_length;
        logic [BYTE_W-1:0]  read_data;
    } t_frame_result;

    // receiver predictor and in-order result checker
    class frame_scoreboard;
        logic [BYTE_W-1:0]    store_mem [DEPTH];
        bit                   written   [DEPTH];
        logic [INDEX_W-1:0]   count;
        t_bracket             bracket;
        bit                   busy;
        logic [EXP_LEN_W-1:0] exp_len;
        bit                   cmd_pending;
        bit                   cmd_mode;
        t_frame_result        expq [$];
        int                   errors;
        int                   checked;
        int                   frames;
        int                   takes;
        int                   readies;

        function new();
            foreach (store_mem[i]) begin
                store_mem[i] = '0;
                written[i]   = 1'b0;
            end
            count       = '0;
            bracket     = BR_IDLE;
            busy        = 1'b0;
            exp_len     = '0;
            cmd_pending = 1'b0;
            cmd_mode    = 1'b0;
            errors      = 0;
            checked     = 0;
            frames      = 0;
            takes       = 0;
            readies     = 0;
        endfunction

        function int outstanding();
            return expq.size();
        endfunction

        function void set_mode(logic mode);
            cmd_mode = mode;
        endfunction

        // store at the write count, which wraps at the buffer depth
        function void put_byte(logic [BYTE_W-1:0] b);
            store_mem[count] = b;
            written[count]   = 1'b1;
            count = (count == DEPTH - 1) ? '0 : count + 1'b1;
        endfunction

        function void note_word(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] b,
                                logic [INDEX_W-1:0] idx);
            t_frame_result r;
            r = '0;
            case (kind)
                KIND_RX_BYTE: begin
                    if (cmd_mode) begin
                        // bracket framing, bytes ignored once closed
                        case (bracket)
                            BR_IDLE: begin
                                if (b == OPEN_MARK)
                                    bracket = BR_OPEN;
                                else if (b == CLOSE_MARK)
                                    bracket = BR_CLOSED;
                            end
                            BR_OPEN: begin
                                if (b == CLOSE_MARK)
                                    bracket = BR_CLOSED;
                                else
                                    put_byte(b);
                            end
                            default: ;
                        endcase
                        cmd_pending = (bracket == BR_CLOSED);
                    end else begin
                        // length framing, burst starts from idle
                        if (!busy) begin
                            count         = '0;
                            busy          = 1'b1;
                            r.ready_event = 1'b1;
                            readies++;
                        end
                        put_byte(b);
                        if (count == HEADER_LEN)
                            exp_len = EXP_LEN_W'(HEADER_LEN + {store_mem[HEADER_LEN - 2],
                                                               store_mem[HEADER_LEN - 1]});
                        if ({{(EXP_LEN_W - INDEX_W){1'b0}}, count} == exp_len) begin
                            r.frame_received = 1'b1;
                            frames++;
                        end
                    end
                end
                KIND_RESP_SENT: busy = 1'b0;
                KIND_TX_DONE: begin
                    if (!cmd_mode)
                        count = '0;
                end
                KIND_TAKE_CMD: begin
                    if (cmd_pending) begin
                        r.taken_length = count;
                        count          = '0;
                        bracket        = BR_IDLE;
                        cmd_pending    = 1'b0;
                        takes++;
                    end
                end
                KIND_READ_BUF: begin
                    if (idx < DEPTH)
                        r.read_data = store_mem[idx];
                end
                default: ;
            endcase
            r.byte_count    = count;
            r.command_ready = cmd_pending;
            expq.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [INDEX_W-1:0] cnt, logic rdy, logic frm, logic cmd,
                          logic [INDEX_W-1:0] tk, logic [BYTE_W-1:0] rd);
            t_frame_result want;
            if (expq.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                want = expq.pop_front();
                checked++;
                if (cnt !== want.byte_count)
                    report($sformatf("word %0d byte_count %0d, expected %0d",
                                     checked, cnt, want.byte_count));
                if (rdy !== want.ready_event)
                    report($sformatf("word %0d ready_event %b, expected %b",
                                     checked, rdy, want.ready_event));
                if (frm !== want.frame_received)
                    report($sformatf("word %0d frame_received %b, expected %b",
                                     checked, frm, want.frame_received));
                if (cmd !== want.command_ready)
                    report($sformatf("word %0d command_ready %b, expected %b",
                                     checked, cmd, want.command_ready));
                if (tk !== want.taken_length)
                    report($sformatf("word %0d taken_length %0d, expected %0d",
                                     checked, tk, want.taken_length));
                if (rd !== want.read_data)
                    report($sformatf("word %0d read_data %02h, expected %02h",
                                     checked, rd, want.read_data));
            end
        endtask
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic               i_cfg_data   = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic [KIND_W-1:0]  i_kind       = KIND_RX_BYTE;
    logic [BYTE_W-1:0]  i_rx_byte    = '0;
    logic [INDEX_W-1:0] i_read_index = '0;
    logic               i_out_ready  = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [INDEX_W-1:0] o_byte_count;
    logic               o_ready_event;
    logic               o_frame_received;
    logic               o_command_ready;
    logic [INDEX_W-1:0] o_taken_length;
    logic [BYTE_W-1:0]  o_read_data;

    frame_scoreboard sb;
    int words_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;

    serial_frame_receiver_dual_mode #(
        .BUFFER_DEPTH  (DEPTH),
        .HEADER_LENGTH (HEADER_LEN)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_rx_byte        (i_rx_byte),
        .i_read_index     (i_read_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_count     (o_byte_count),
        .o_ready_event    (o_ready_event),
        .o_frame_received (o_frame_received),
        .o_command_ready  (o_command_ready),
        .o_taken_length   (o_taken_length),
        .o_read_data      (o_read_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side back-pressure, with long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_requests != holds_done) begin
            holds_done  <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watch config writes, accepted words and result words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.set_mode(i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_word(i_kind, i_rx_byte, i_read_index);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_byte_count, o_ready_event, o_frame_received,
                                o_command_ready, o_taken_length, o_read_data);
        end
    end

    // offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
                             input logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_rx_byte    <= b;
        i_read_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_word(KIND_RX_BYTE, b, INDEX_W'($urandom_range(DEPTH - 1)));
    endtask

    task automatic send_ctl(input logic [KIND_W-1:0] kind);
        send_word(kind, BYTE_W'($urandom_range(255)), INDEX_W'($urandom_range(DEPTH - 1)));
    endtask

    // reads pick an entry already written, or a random one while none is
    function automatic logic [INDEX_W-1:0] pick_index();
        int start;
        int i;
        start = $urandom_range(DEPTH - 1);
        for (i = 0; i < DEPTH; i++)
            if (sb.written[(start + i) % DEPTH])
                return INDEX_W'((start + i) % DEPTH);
        return INDEX_W'(start);
    endfunction

    task automatic send_read();
        send_word(KIND_READ_BUF, BYTE_W'($urandom_range(255)), pick_index());
    endtask

    // command body byte, never the closing mark
    function automatic logic [BYTE_W-1:0] body_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(255));
        if (b == CLOSE_MARK)
            b = OPEN_MARK;
        return b;
    endfunction

    task automatic noise();
        logic [KIND_W-1:0] k;
        k = KIND_W'($urandom_range((1 << KIND_W) - 1));
        if (k == KIND_READ_BUF)
            send_read();
        else
            send_word(k, BYTE_W'($urandom_range(255)), INDEX_W'($urandom_range(DEPTH - 1)));
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly well-formed length frames, some broken or stray words
    task automatic modbus_traffic();
        int r;
        int len;
        int n;
        r = $urandom_range(99);
        if (r < 15) begin
            noise();
        end else begin
            if ($urandom_range(1))
                send_ctl(KIND_RESP_SENT);
            else if ($urandom_range(3) == 0)
                send_ctl(KIND_TX_DONE);
            r = $urandom_range(99);
            if (r < 75)
                len = $urandom_range(12);
            else if (r < 80)
                len = $urandom_range(130, 100);
            else
                len = $urandom_range(16'hFFFF);
            repeat (HEADER_LEN - 2) send_byte(BYTE_W'($urandom_range(255)));
            send_byte(len[15:8]);
            send_byte(len[7:0]);
            n = (len > 130) ? $urandom_range(8) : len;
            repeat (n) send_byte(BYTE_W'($urandom_range(255)));
            repeat ($urandom_range(2)) send_read();
        end
    endtask

    // mostly bracketed commands that get taken, some left open or stray
    task automatic command_traffic();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 15) begin
            noise();
        end else if (r < 25) begin
            send_byte(CLOSE_MARK);
            send_ctl(KIND_TAKE_CMD);
        end else begin
            send_byte(OPEN_MARK);
            n = ($urandom_range(24) == 0) ? $urandom_range(130, 100) : $urandom_range(10);
            repeat (n) send_byte(body_byte());
            if ($urandom_range(9) != 0)
                send_byte(CLOSE_MARK);
            if ($urandom_range(3) == 0)
                send_byte(BYTE_W'($urandom_range(255)));
            if ($urandom_range(2) == 0)
                send_read();
            if ($urandom_range(5) != 0)
                send_ctl(KIND_TAKE_CMD);
        end
    endtask

    task automatic run_phase(input logic mode, input int idle_pct, input int stall,
                             input bit squeeze);
        int first;
        bit held;
        drain();
        write_mode(mode);
        send_idle_pct = idle_pct;
        stall_pct    <= stall;
        first = words_sent;
        held  = 1'b0;
        while (words_sent - first < PHASE_WORDS) begin
            // long result hold-off while words keep coming, fills the block
            if (squeeze && !held && words_sent - first >= PHASE_WORDS / 3) begin
                hold_requests <= hold_requests + 1;
                held = 1'b1;
            end
            if (mode)
                command_traffic();
            else
                modbus_traffic();
        end
    endtask

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [KIND_W-1:0] k;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length mode basics: burst start, unused kinds, read, empty take
        write_mode(1'b0);
        send_byte(8'hA5);
        for (k = KIND_READ_BUF + 3'd1; k != 3'd0; k = k + 3'd1)
            send_ctl(k);
        send_word(KIND_READ_BUF, 8'h00, '0);
        send_ctl(KIND_TAKE_CMD);

        // command mode: transmit done, close while idle, bytes while closed, take
        drain();
        write_mode(1'b1);
        send_ctl(KIND_TX_DONE);
        send_byte(CLOSE_MARK);
        send_byte(8'h55);
        send_ctl(KIND_TAKE_CMD);

        // fill the buffer to one short of the wrap, left pending
        send_byte(OPEN_MARK);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(OPEN_MARK);
        repeat (DEPTH - 4) send_byte(body_byte());
        send_byte(CLOSE_MARK);

        // length mode: wrap to zero with no length decoded yet, take here
        drain();
        write_mode(1'b0);
        send_byte(BYTE_W'($urandom_range(255)));
        send_byte(BYTE_W'($urandom_range(255)));
        send_ctl(KIND_TAKE_CMD);

        // largest length field, then transmit done and a zero length frame
        send_ctl(KIND_RESP_SENT);
        repeat (HEADER_LEN - 2) send_byte(BYTE_W'($urandom_range(255)));
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_word(KIND_READ_BUF, 8'hFF, INDEX_W'(DEPTH - 1));
        send_ctl(KIND_TX_DONE);
        repeat (HEADER_LEN - 2) send_byte(BYTE_W'($urandom_range(255)));
        send_byte(8'h00);
        send_byte(8'h00);

        // random traffic under four back-pressure profiles
        run_phase(1'b0, 0, 0, 1'b1);
        run_phase(1'b1, 83, 0, 1'b0);
        run_phase(1'b0, 0, 83, 1'b0);
        run_phase(1'b1, 23, 23, 1'b0);
        drain();

        $display("%0d words sent, %0d results checked, both framing modes",
                 words_sent, sb.checked);
        $display("%0d bursts started, %0d frames received, %0d commands taken",
                 sb.readies, sb.frames, sb.takes);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
